### design/scpe_pkg.sv
// ----------------------------------------------------------------------------
// Sparse convolution PE package
// Shared types, sizes and the small stride divider used by the PE.
// ----------------------------------------------------------------------------
package scpe_pkg;

  localparam int unsigned MaxFilters   = 16;
  localparam int unsigned MaxOutDim    = 32;
  localparam int unsigned WeightDepth  = 256;
  localparam int unsigned MaxKernelDim = 16;

  localparam int unsigned FiltW = $clog2(MaxFilters);
  localparam int unsigned PosW  = $clog2(MaxOutDim);
  localparam int unsigned AccAw = FiltW + 2 * PosW;
  localparam int unsigned WAw   = $clog2(WeightDepth);
  localparam int unsigned KerW  = $clog2(MaxKernelDim);
  localparam int unsigned WEntW = 16 + FiltW + 2 * KerW;

  typedef enum logic [2:0] {
    OP_CLEAR_ALL = 3'd0,
    OP_CLEAR_WT  = 3'd1,
    OP_LOAD_WT   = 3'd2,
    OP_ACT       = 3'd3,
    OP_BIAS      = 3'd4,
    OP_READ      = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_BAD  = 2'd2,
    STS_SAT  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_STRIDE  = 3'd0,
    CFG_PADDING = 3'd1,
    CFG_OUT_W   = 3'd2,
    CFG_OUT_H   = 3'd3,
    CFG_RELU    = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WRD,
    ST_WEVAL,
    ST_AREAD,
    ST_AADD,
    ST_RDOUT,
    ST_DONE
  } state_e;

  // Result of mapping one weight against the current activation
  typedef struct packed {
    logic            hit;
    logic [PosW-1:0] w;
    logic [PosW-1:0] h;
  } map_t;

  // Divide an 8-bit value by a stride of 1..7 (reciprocal multiply)
  function automatic logic [7:0] div_small(input logic [7:0] x, input logic [2:0] st);
    logic [18:0] p3;
    logic [18:0] p5;
    logic [18:0] p7;
    logic [7:0]  q;
    p3 = {11'd0, x} * 19'd171;
    p5 = {11'd0, x} * 19'd205;
    p7 = {11'd0, x} * 19'd293;
    unique case (st)
      3'd2:    q = {1'b0, x[7:1]};
      3'd3:    q = p3[16:9];
      3'd4:    q = {2'b0, x[7:2]};
      3'd5:    q = p5[17:10];
      3'd6:    q = p3[17:10];
      3'd7:    q = p7[18:11];
      default: q = x;
    endcase
    return q;
  endfunction

  // Remainder of an 8-bit value by a stride of 1..7
  function automatic logic [7:0] mod_small(input logic [7:0] x, input logic [2:0] st);
    logic [10:0] qs;
    qs = {3'd0, div_small(x, st)} * {8'd0, st};
    return x - qs[7:0];
  endfunction

endpackage

### design/scpe_map.sv
// ----------------------------------------------------------------------------
// Weight to output mapper
// Checks the stride phase of one weight against the activation and gives
// the output position and whether it lies inside the bounds.
// ----------------------------------------------------------------------------
module scpe_map (
  input  logic [7:0]               act_row_i,
  input  logic [7:0]               act_col_i,
  input  logic [scpe_pkg::KerW-1:0] w_row_i,
  input  logic [scpe_pkg::KerW-1:0] w_col_i,
  input  logic [1:0]               pad_i,
  input  logic [2:0]               st_i,
  input  logic [5:0]               bw_i,
  input  logic [5:0]               bh_i,
  output scpe_pkg::map_t           map_o
);

  logic [7:0] rp, sp;
  logic       phase_ok;
  logic [8:0] dr, dc;
  logic [7:0] ar, ac, qr, qc;
  logic       ok_w, ok_h;

  // compare stride phases
  assign rp = {{(8-scpe_pkg::KerW){1'b0}}, w_row_i} + {6'd0, pad_i};
  assign sp = {{(8-scpe_pkg::KerW){1'b0}}, w_col_i} + {6'd0, pad_i};
  assign phase_ok = (scpe_pkg::mod_small(rp, st_i) == scpe_pkg::mod_small(act_row_i, st_i)) &&
                    (scpe_pkg::mod_small(sp, st_i) == scpe_pkg::mod_small(act_col_i, st_i));

  // signed offsets, divided toward zero
  assign dr = {1'b0, act_row_i} - {{(9-scpe_pkg::KerW){1'b0}}, w_row_i};
  assign dc = {1'b0, act_col_i} - {{(9-scpe_pkg::KerW){1'b0}}, w_col_i};
  assign ar = dr[8] ? 8'(-dr) : dr[7:0];
  assign ac = dc[8] ? 8'(-dc) : dc[7:0];
  assign qr = scpe_pkg::div_small(ar, st_i);
  assign qc = scpe_pkg::div_small(ac, st_i);

  // bounds: a negative offset survives only when it truncates to zero
  assign ok_w = (qr < {2'b0, bw_i}) && (!dr[8] || (qr == 8'd0));
  assign ok_h = (qc < {2'b0, bh_i}) && (!dc[8] || (qc == 8'd0));

  assign map_o.hit = phase_ok && ok_w && ok_h;
  assign map_o.w   = dr[8] ? '0 : qr[scpe_pkg::PosW-1:0];
  assign map_o.h   = dc[8] ? '0 : qc[scpe_pkg::PosW-1:0];

endmodule

### design/sparse_cartesian_conv_pe_top.sv
// ----------------------------------------------------------------------------
// Sparse convolution processing element
// Weight queue and accumulator file in synchronous RAMs, one weight at a time
// paired with each activation, read-modify-write of the accumulator.
// ----------------------------------------------------------------------------
//  channel   signals                                  direction
//  in        in_valid_i / in_stall_o + item fields    into block
//  out       out_valid_o / out_stall_i + data, status out of block
//  cfg       cfg_valid_i / cfg_ready_o, index, data   into block
//
// An activation reads each stored weight in turn and checks where it lands; each
// weight that lands in the output adds an accumulator RAM read-add-write.
// Clear all sweeps 16384 accumulator rows.
// After reset the same sweep runs before the first beat is taken.
// A finished result waits in the output register while the next beat enters.
module sparse_cartesian_conv_pe_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] value_i,
  input  logic [3:0]         filter_i,
  input  logic [7:0]         coord_row_i,
  input  logic [7:0]         coord_col_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [47:0] data_o,
  output logic [1:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  localparam int unsigned AccAw = scpe_pkg::AccAw;
  localparam int unsigned WAw   = scpe_pkg::WAw;
  localparam int unsigned WEntW = scpe_pkg::WEntW;
  localparam int unsigned FiltW = scpe_pkg::FiltW;
  localparam int unsigned KerW  = scpe_pkg::KerW;
  localparam int unsigned PosW  = scpe_pkg::PosW;

  scpe_pkg::state_e state_q, state_d;

  logic [2:0]  stride_q;
  logic [1:0]  padding_q;
  logic [5:0]  out_w_q, out_h_q;
  logic        relu_q;

  logic        item_q;
  logic [2:0]  op_q;
  logic [31:0] val_q;
  logic [3:0]  flt_q;
  logic [7:0]  row_q, col_q;
  logic [WAw:0]   wcnt_q, idx_q;
  logic [AccAw-1:0] clr_q, acc_addr_q;
  logic signed [31:0] prod_q;
  logic [47:0] res_data_q, out_data_q;
  logic [1:0]  res_status_q, out_status_q;
  logic        out_valid_q;
  logic [31:0] bias_q [scpe_pkg::MaxFilters];

  logic [WEntW-1:0] wmem [scpe_pkg::WeightDepth];
  logic [WEntW-1:0] wm_rd_q;
  logic [47:0]      amem [2**AccAw];
  logic [47:0]      acc_rd_q;

  logic [2:0]  st_eff;
  logic [5:0]  bw, bh;
  logic        val16, val_zero, wt_bad, rd_bad, last_w, clr_last;
  logic        in_acc, out_load;
  logic        wm_we, acc_we;
  logic [AccAw-1:0] acc_waddr;
  logic [47:0] acc_wdata;
  logic [48:0] add_sum, rd_sum;
  logic [47:0] add_clamp, rd_clamp, rd_final;
  logic        add_sat, rd_sat;
  scpe_pkg::map_t map;

  // effective stride and bounds
  assign st_eff = (stride_q == 3'd0) ? 3'd1 : stride_q;
  assign bw     = (out_w_q > 6'(scpe_pkg::MaxOutDim)) ? 6'(scpe_pkg::MaxOutDim) : out_w_q;
  assign bh     = (out_h_q > 6'(scpe_pkg::MaxOutDim)) ? 6'(scpe_pkg::MaxOutDim) : out_h_q;

  // item checks
  assign val16    = (&val_q[31:15]) || (~|val_q[31:15]);
  assign val_zero = (val_q == 32'd0);
  assign wt_bad   = !val16 || (row_q[7:KerW] != '0) || (col_q[7:KerW] != '0);
  assign rd_bad   = (row_q >= {2'b0, bw}) || (col_q >= {2'b0, bh});
  assign last_w   = ((idx_q + 1'b1) == wcnt_q);
  assign clr_last = &clr_q;

  // handshakes
  assign in_stall_o  = (state_q != scpe_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == scpe_pkg::ST_IDLE);
  assign out_load    = (state_q == scpe_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;
  assign status_o    = out_status_q;
  assign cfg_ready_o = 1'b1;

  scpe_map u_map (
    .act_row_i (row_q),
    .act_col_i (col_q),
    .w_row_i   (wm_rd_q[2*KerW-1:KerW]),
    .w_col_i   (wm_rd_q[KerW-1:0]),
    .pad_i     (padding_q),
    .st_i      (st_eff),
    .bw_i      (bw),
    .bh_i      (bh),
    .map_o     (map)
  );

  // accumulate with 48-bit saturation
  assign add_sum = {acc_rd_q[47], acc_rd_q} + {{17{prod_q[31]}}, prod_q};
  assign add_sat = add_sum[48] != add_sum[47];
  assign add_clamp = !add_sat ? add_sum[47:0] :
                     (add_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});

  // bias plus accumulator for reads
  assign rd_sum = {acc_rd_q[47], acc_rd_q} + {{17{bias_q[flt_q][31]}}, bias_q[flt_q]};
  assign rd_sat = rd_sum[48] != rd_sum[47];
  assign rd_clamp = !rd_sat ? rd_sum[47:0] :
                    (rd_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});
  assign rd_final = (relu_q && rd_clamp[47]) ? 48'd0 : rd_clamp;

  // RAM write strobes
  assign wm_we     = (state_q == scpe_pkg::ST_EXEC) && (op_q == scpe_pkg::OP_LOAD_WT) &&
                     !wt_bad && !val_zero && !wcnt_q[WAw];
  assign acc_we    = (state_q == scpe_pkg::ST_CLEAR) || (state_q == scpe_pkg::ST_AADD);
  assign acc_waddr = (state_q == scpe_pkg::ST_CLEAR) ? clr_q : acc_addr_q;
  assign acc_wdata = (state_q == scpe_pkg::ST_CLEAR) ? 48'd0 : add_clamp;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scpe_pkg::ST_CLEAR: begin
        if (clr_last) state_d = item_q ? scpe_pkg::ST_DONE : scpe_pkg::ST_IDLE;
      end
      scpe_pkg::ST_IDLE: begin
        if (in_acc) state_d = scpe_pkg::ST_EXEC;
      end
      scpe_pkg::ST_EXEC: begin
        unique case (op_q)
          scpe_pkg::OP_CLEAR_ALL: state_d = scpe_pkg::ST_CLEAR;
          scpe_pkg::OP_ACT: begin
            if (!val16 || val_zero || (wcnt_q == '0)) state_d = scpe_pkg::ST_DONE;
            else state_d = scpe_pkg::ST_WRD;
          end
          scpe_pkg::OP_READ: state_d = rd_bad ? scpe_pkg::ST_DONE : scpe_pkg::ST_AREAD;
          default: state_d = scpe_pkg::ST_DONE;
        endcase
      end
      scpe_pkg::ST_WRD:   state_d = scpe_pkg::ST_WEVAL;
      scpe_pkg::ST_WEVAL: begin
        if (map.hit) state_d = scpe_pkg::ST_AREAD;
        else state_d = last_w ? scpe_pkg::ST_DONE : scpe_pkg::ST_WRD;
      end
      scpe_pkg::ST_AREAD: begin
        state_d = (op_q == scpe_pkg::OP_READ) ? scpe_pkg::ST_RDOUT : scpe_pkg::ST_AADD;
      end
      scpe_pkg::ST_AADD:  state_d = last_w ? scpe_pkg::ST_DONE : scpe_pkg::ST_WRD;
      scpe_pkg::ST_RDOUT: state_d = scpe_pkg::ST_DONE;
      scpe_pkg::ST_DONE: begin
        if (out_load) state_d = scpe_pkg::ST_IDLE;
      end
      default: state_d = scpe_pkg::ST_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= scpe_pkg::ST_CLEAR;
      stride_q     <= 3'd1;
      padding_q    <= 2'd0;
      out_w_q      <= 6'd32;
      out_h_q      <= 6'd32;
      relu_q       <= 1'b0;
      item_q       <= 1'b0;
      wcnt_q       <= '0;
      idx_q        <= '0;
      clr_q        <= '0;
      res_status_q <= scpe_pkg::STS_OK;
      res_data_q   <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < scpe_pkg::MaxFilters; i++) bias_q[i] <= '0;
    end else begin
      state_q <= state_d;

      // take configuration beats
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          scpe_pkg::CFG_STRIDE:  stride_q  <= cfg_data_i[2:0];
          scpe_pkg::CFG_PADDING: padding_q <= cfg_data_i[1:0];
          scpe_pkg::CFG_OUT_W:   out_w_q   <= cfg_data_i[5:0];
          scpe_pkg::CFG_OUT_H:   out_h_q   <= cfg_data_i[5:0];
          scpe_pkg::CFG_RELU:    relu_q    <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (in_acc) item_q <= 1'b1;

      unique case (state_q)
        scpe_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
        scpe_pkg::ST_EXEC: begin
          res_data_q   <= '0;
          res_status_q <= scpe_pkg::STS_OK;
          idx_q        <= '0;
          clr_q        <= '0;
          unique case (op_q)
            scpe_pkg::OP_CLEAR_ALL: begin
              wcnt_q <= '0;
              for (int i = 0; i < scpe_pkg::MaxFilters; i++) bias_q[i] <= '0;
            end
            scpe_pkg::OP_CLEAR_WT: wcnt_q <= '0;
            scpe_pkg::OP_LOAD_WT: begin
              if (wt_bad) res_status_q <= scpe_pkg::STS_BAD;
              else if (!val_zero) begin
                if (wcnt_q[WAw]) res_status_q <= scpe_pkg::STS_FULL;
                else wcnt_q <= wcnt_q + 1'b1;
              end
            end
            scpe_pkg::OP_ACT: begin
              if (!val16) res_status_q <= scpe_pkg::STS_BAD;
            end
            scpe_pkg::OP_BIAS: bias_q[flt_q] <= val_q;
            scpe_pkg::OP_READ: begin
              if (rd_bad) res_status_q <= scpe_pkg::STS_BAD;
            end
            default: res_status_q <= scpe_pkg::STS_BAD;
          endcase
        end
        scpe_pkg::ST_WEVAL: begin
          if (!map.hit) idx_q <= idx_q + 1'b1;
        end
        scpe_pkg::ST_AADD: begin
          idx_q <= idx_q + 1'b1;
          if (add_sat) res_status_q <= scpe_pkg::STS_SAT;
        end
        scpe_pkg::ST_RDOUT: begin
          res_data_q   <= rd_final;
          res_status_q <= rd_sat ? scpe_pkg::STS_SAT : scpe_pkg::STS_OK;
        end
        scpe_pkg::ST_DONE: begin
          if (out_load) item_q <= 1'b0;
        end
        default: ;
      endcase

      // output register
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= operation_i;
      val_q <= value_i;
      flt_q <= filter_i;
      row_q <= coord_row_i;
      col_q <= coord_col_i;
    end
    if ((state_q == scpe_pkg::ST_EXEC) && (op_q == scpe_pkg::OP_READ)) begin
      acc_addr_q <= {flt_q, row_q[PosW-1:0], col_q[PosW-1:0]};
    end
    if (state_q == scpe_pkg::ST_WEVAL) begin
      acc_addr_q <= {wm_rd_q[FiltW+2*KerW-1:2*KerW], map.w, map.h};
      prod_q     <= $signed(val_q[15:0]) * $signed(wm_rd_q[WEntW-1:FiltW+2*KerW]);
    end
    if (out_load) begin
      out_data_q   <= res_data_q;
      out_status_q <= res_status_q;
    end
  end

  // weight queue RAM
  always_ff @(posedge clk_i) begin
    if (wm_we) begin
      wmem[wcnt_q[WAw-1:0]] <= {val_q[15:0], flt_q[FiltW-1:0], row_q[KerW-1:0],
                                col_q[KerW-1:0]};
    end
    wm_rd_q <= wmem[idx_q[WAw-1:0]];
  end

  // accumulator RAM
  always_ff @(posedge clk_i) begin
    if (acc_we) amem[acc_waddr] <= acc_wdata;
    acc_rd_q <= amem[acc_addr_q];
  end

endmodule

### tb/sparse_cartesian_conv_pe_top_test.sv
// ----------------------------------------------------------------------------
// Sparse convolution PE testbench
// Drives item beats with random gaps and output stalls, predicts every result
// with a behavioral copy of the PE and compares data and status per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_cartesian_conv_pe_top_test;

  localparam int unsigned CycleLimit = 6000000;
  localparam int unsigned SettleCycles = 40;
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;
  localparam longint AccMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint AccMin = -AccMax - 1;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [3:0]         filter;
    logic [7:0]         row;
    logic [7:0]         col;
  } pe_beat_t;

  typedef struct {
    logic signed [47:0] data;
    logic [1:0]         status;
  } pe_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         operation_i = '0;
  logic signed [31:0] value_i = '0;
  logic [3:0]         filter_i = '0;
  logic [7:0]         coord_row_i = '0;
  logic [7:0]         coord_col_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [47:0] data_o;
  logic [1:0]         status_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [7:0]         cfg_data_i = '0;

  // Shadow state of the PE
  int     pe_stride = 1;
  int     pe_padding = 0;
  int     pe_out_w = 32;
  int     pe_out_h = 32;
  bit     pe_relu = 1'b0;
  int     wq_value [scpe_pkg::WeightDepth];
  int     wq_filter [scpe_pkg::WeightDepth];
  int     wq_row [scpe_pkg::WeightDepth];
  int     wq_col [scpe_pkg::WeightDepth];
  int     wq_count = 0;
  longint acc_mem [scpe_pkg::MaxFilters*scpe_pkg::MaxOutDim*scpe_pkg::MaxOutDim];
  int     bias_mem [scpe_pkg::MaxFilters];

  pe_result_t owed_results [$];
  int          mismatches = 0;
  int unsigned cycles = 0;
  int          beats_sent = 0;
  int          hold_cnt = 0;
  int          stall_run = 0;
  int          free_run = 0;
  bit          quiet = 1'b0;

  sparse_cartesian_conv_pe_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .filter_i    (filter_i),
    .coord_row_i (coord_row_i),
    .coord_col_i (coord_col_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (data_o),
    .status_o    (status_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver stall: long hold-off on request, else short and rare long runs
  always @(posedge clk_i) begin
    int r;
    if (hold_cnt > 0) begin
      out_stall_i <= 1'b1;
      hold_cnt--;
    end else if (stall_run > 0) begin
      out_stall_i <= 1'b1;
      stall_run--;
    end else if (free_run > 0 || quiet) begin
      out_stall_i <= 1'b0;
      if (free_run > 0) free_run--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_stall_i <= 1'b0;
        free_run = $urandom_range(0, 8);
      end else if (r < 95) begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(10, 50);
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    pe_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result data %0d status %0d", data_o, status_o);
      end else begin
        want = owed_results.pop_front();
        if (data_o !== want.data || status_o !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: data exp %0d got %0d, status exp %0d got %0d",
                     want.data, data_o, want.status, status_o);
        end
      end
    end
  end

  function automatic longint clamp48(longint v, inout bit sat);
    if (v > AccMax) begin
      sat = 1'b1;
      return AccMax;
    end
    if (v < AccMin) begin
      sat = 1'b1;
      return AccMin;
    end
    return v;
  endfunction

  function automatic int div_toward_zero(int d, int q);
    if (d < 0) return -((-d) / q);
    return d / q;
  endfunction

  // Work out the result of one beat and advance the shadow state
  function automatic void conv_step(input pe_beat_t b, output pe_result_t res);
    longint v, data;
    bit     sat, v16;
    int     st, bw, bh, px, py, r, s, w, h, pos, row, col, flt;
    v = b.value;
    row = b.row;
    col = b.col;
    flt = b.filter;
    sat = 1'b0;
    data = 0;
    res.status = scpe_pkg::STS_OK;
    st = (pe_stride == 0) ? 1 : pe_stride;
    bw = (pe_out_w > scpe_pkg::MaxOutDim) ? scpe_pkg::MaxOutDim : pe_out_w;
    bh = (pe_out_h > scpe_pkg::MaxOutDim) ? scpe_pkg::MaxOutDim : pe_out_h;
    v16 = (v >= -32768) && (v <= 32767);
    case (b.op)
      scpe_pkg::OP_CLEAR_ALL: begin
        wq_count = 0;
        foreach (acc_mem[i]) acc_mem[i] = 0;
        foreach (bias_mem[i]) bias_mem[i] = 0;
      end
      scpe_pkg::OP_CLEAR_WT: wq_count = 0;
      scpe_pkg::OP_LOAD_WT: begin
        if (!v16 || row >= scpe_pkg::MaxKernelDim || col >= scpe_pkg::MaxKernelDim) begin
          res.status = scpe_pkg::STS_BAD;
        end else if (v != 0) begin
          if (wq_count >= scpe_pkg::WeightDepth) begin
            res.status = scpe_pkg::STS_FULL;
          end else begin
            wq_value[wq_count] = int'(v);
            wq_filter[wq_count] = flt;
            wq_row[wq_count] = row;
            wq_col[wq_count] = col;
            wq_count++;
          end
        end
      end
      scpe_pkg::OP_ACT: begin
        if (!v16) begin
          res.status = scpe_pkg::STS_BAD;
        end else if (v != 0) begin
          px = row % st;
          py = col % st;
          for (int i = 0; i < wq_count; i++) begin
            r = wq_row[i];
            s = wq_col[i];
            if ((r + pe_padding) % st != px || (s + pe_padding) % st != py) continue;
            w = div_toward_zero(row - r, st);
            h = div_toward_zero(col - s, st);
            if (w < 0 || w >= bw || h < 0 || h >= bh) continue;
            pos = wq_filter[i] * scpe_pkg::MaxOutDim * scpe_pkg::MaxOutDim +
                  w * scpe_pkg::MaxOutDim + h;
            acc_mem[pos] = clamp48(acc_mem[pos] + v * longint'(wq_value[i]), sat);
          end
          if (sat) res.status = scpe_pkg::STS_SAT;
        end
      end
      scpe_pkg::OP_BIAS: bias_mem[flt] = int'(v);
      scpe_pkg::OP_READ: begin
        if (row >= bw || col >= bh) begin
          res.status = scpe_pkg::STS_BAD;
        end else begin
          pos = flt * scpe_pkg::MaxOutDim * scpe_pkg::MaxOutDim + row * scpe_pkg::MaxOutDim + col;
          data = clamp48(longint'(bias_mem[flt]) + acc_mem[pos], sat);
          if (pe_relu && data < 0) data = 0;
          if (sat) res.status = scpe_pkg::STS_SAT;
        end
      end
      default: res.status = scpe_pkg::STS_BAD;
    endcase
    res.data = data[47:0];
  endfunction

  function automatic pe_beat_t mk_beat(logic [2:0] op, int value, int flt, int row, int col);
    pe_beat_t b;
    b.op = op;
    b.value = value;
    b.filter = flt[3:0];
    b.row = row[7:0];
    b.col = col[7:0];
    return b;
  endfunction

  function automatic int rand_s16();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32767;
    if (r == 1) return -32768;
    if (r == 2) return 0;
    return int'(shortint'($urandom_range(0, 65535)));
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one beat, hold it until taken, then record its prediction
  task automatic send_beat(pe_beat_t b);
    pe_result_t res;
    int gap;
    in_valid_i <= 1'b1;
    operation_i <= b.op;
    value_i <= b.value;
    filter_i <= b.filter;
    coord_row_i <= b.row;
    coord_col_i <= b.col;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    conv_step(b, res);
    owed_results.insert(owed_results.size(), res);
    beats_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait out every owed result
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(scpe_pkg::cfg_idx_e idx, logic [7:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      scpe_pkg::CFG_STRIDE:  pe_stride = int'(d[2:0]);
      scpe_pkg::CFG_PADDING: pe_padding = int'(d[1:0]);
      scpe_pkg::CFG_OUT_W:   pe_out_w = int'(d[5:0]);
      scpe_pkg::CFG_OUT_H:   pe_out_h = int'(d[5:0]);
      scpe_pkg::CFG_RELU:    pe_relu = d[0];
      default: ;
    endcase
  endtask

  task automatic set_config(int st, int pad, int ow, int oh, int relu);
    drain();
    write_reg(scpe_pkg::CFG_STRIDE, 8'(st));
    write_reg(scpe_pkg::CFG_PADDING, 8'(pad));
    write_reg(scpe_pkg::CFG_OUT_W, 8'(ow));
    write_reg(scpe_pkg::CFG_OUT_H, 8'(oh));
    write_reg(scpe_pkg::CFG_RELU, 8'(relu));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic pe_beat_t noise_beat();
    logic [2:0] op;
    op = 3'($urandom_range(0, 7));
    if (op == scpe_pkg::OP_CLEAR_ALL && $urandom_range(0, 15) != 0) op = scpe_pkg::OP_CLEAR_WT;
    return mk_beat(op, $urandom, $urandom_range(0, 15), $urandom_range(0, 255),
                   $urandom_range(0, 255));
  endfunction

  // Well-formed layer passes with random content, mixed with noise beats
  task automatic run_conv_phase(int n_beats);
    int stop, kmax, bw, bh;
    stop = beats_sent + n_beats;
    bw = (pe_out_w > scpe_pkg::MaxOutDim) ? scpe_pkg::MaxOutDim : pe_out_w;
    bh = (pe_out_h > scpe_pkg::MaxOutDim) ? scpe_pkg::MaxOutDim : pe_out_h;
    while (beats_sent < stop) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(noise_beat());
      end else begin
        send_beat(mk_beat(scpe_pkg::OP_CLEAR_WT, $urandom, $urandom_range(0, 15), 0, 0));
        kmax = ($urandom_range(0, 3) == 0) ? 15 : 3;
        repeat ($urandom_range(1, 12))
          send_beat(mk_beat(scpe_pkg::OP_LOAD_WT, rand_s16(), $urandom_range(0, 15),
                            $urandom_range(0, kmax), $urandom_range(0, kmax)));
        repeat ($urandom_range(0, 2))
          send_beat(mk_beat(scpe_pkg::OP_BIAS, $urandom, $urandom_range(0, 15), 0, 0));
        repeat ($urandom_range(4, 16)) begin
          if ($urandom_range(0, 7) == 0)
            send_beat(mk_beat(scpe_pkg::OP_ACT, rand_s16(), 0, $urandom_range(0, 255),
                              $urandom_range(0, 255)));
          else
            send_beat(mk_beat(scpe_pkg::OP_ACT, rand_s16(), 0, $urandom_range(0, 40),
                              $urandom_range(0, 40)));
        end
        repeat ($urandom_range(3, 10))
          send_beat(mk_beat(scpe_pkg::OP_READ, 0, $urandom_range(0, 15),
                            $urandom_range(0, bw), $urandom_range(0, bh)));
      end
    end
  endtask

  // Field extremes, every operation and the named corner cases
  task automatic test_directed();
    send_beat(mk_beat(scpe_pkg::OP_CLEAR_ALL, 0, 0, 0, 0));
    send_beat(mk_beat(scpe_pkg::OP_BIAS, 32'h7FFF_FFFF, 15, 0, 0));
    send_beat(mk_beat(scpe_pkg::OP_BIAS, 32'h8000_0000, 0, 0, 0));
    send_beat(mk_beat(scpe_pkg::OP_LOAD_WT, 32767, 15, 15, 15));
    send_beat(mk_beat(scpe_pkg::OP_LOAD_WT, -32768, 0, 0, 0));
    send_beat(mk_beat(scpe_pkg::OP_LOAD_WT, 0, 3, 1, 1));
    send_beat(mk_beat(scpe_pkg::OP_LOAD_WT, 32768, 1, 1, 1));
    send_beat(mk_beat(scpe_pkg::OP_LOAD_WT, -32769, 1, 1, 1));
    send_beat(mk_beat(scpe_pkg::OP_LOAD_WT, 5, 1, 16, 0));
    send_beat(mk_beat(scpe_pkg::OP_LOAD_WT, 5, 1, 0, 255));
    send_beat(mk_beat(scpe_pkg::OP_ACT, 0, 0, 3, 3));
    send_beat(mk_beat(scpe_pkg::OP_ACT, -32769, 0, 3, 3));
    send_beat(mk_beat(scpe_pkg::OP_ACT, 32767, 0, 0, 0));
    send_beat(mk_beat(scpe_pkg::OP_ACT, -32768, 0, 255, 255));
    send_beat(mk_beat(scpe_pkg::OP_ACT, 1234, 0, 20, 31));
    send_beat(mk_beat(scpe_pkg::OP_READ, 0, 0, 0, 0));
    send_beat(mk_beat(scpe_pkg::OP_READ, 0, 15, 5, 16));
    send_beat(mk_beat(scpe_pkg::OP_READ, 0, 15, 31, 31));
    send_beat(mk_beat(scpe_pkg::OP_READ, 0, 0, 32, 0));
    send_beat(mk_beat(OpSpare6, -1, 15, 255, 255));
    send_beat(mk_beat(OpSpare7, 0, 0, 0, 0));
    send_beat(mk_beat(scpe_pkg::OP_CLEAR_WT, 0, 0, 0, 0));
    send_beat(mk_beat(scpe_pkg::OP_ACT, 100, 0, 0, 0));
    send_beat(mk_beat(scpe_pkg::OP_READ, 0, 0, 0, 0));
  endtask

  // Fill the weight queue and push one past it
  task automatic test_queue_full();
    set_config(1, 0, 32, 32, 0);
    send_beat(mk_beat(scpe_pkg::OP_CLEAR_WT, 0, 0, 0, 0));
    for (int i = 0; i <= scpe_pkg::WeightDepth; i++)
      send_beat(mk_beat(scpe_pkg::OP_LOAD_WT, (i % 200) + 1, i % 16, i % 16, (i / 16) % 16));
    send_beat(mk_beat(scpe_pkg::OP_ACT, 7, 0, 20, 20));
    send_beat(mk_beat(scpe_pkg::OP_READ, 0, 4, 16, 16));
  endtask

  // Drive one accumulator into positive saturation, then its read
  task automatic test_saturation();
    set_config(1, 0, 32, 32, 0);
    quiet = 1'b1;
    send_beat(mk_beat(scpe_pkg::OP_CLEAR_ALL, 0, 0, 0, 0));
    repeat (scpe_pkg::WeightDepth) send_beat(mk_beat(scpe_pkg::OP_LOAD_WT, -32768, 0, 0, 0));
    repeat (513) send_beat(mk_beat(scpe_pkg::OP_ACT, -32768, 0, 0, 0));
    send_beat(mk_beat(scpe_pkg::OP_BIAS, 1, 0, 0, 0));
    send_beat(mk_beat(scpe_pkg::OP_READ, 0, 0, 0, 0));
    send_beat(mk_beat(scpe_pkg::OP_CLEAR_WT, 0, 0, 0, 0));
    quiet = 1'b0;
  endtask

  // Hold the receiver off while the sender keeps offering
  task automatic test_backpressure();
    drain();
    hold_cnt = 400;
    quiet = 1'b1;
    repeat (30) send_beat(mk_beat(scpe_pkg::OP_READ, 0, $urandom_range(0, 15), 0, 0));
    quiet = 1'b0;
    drain();
  endtask

  task automatic test_random_layers();
    set_config(1, 0, 32, 32, 0);
    run_conv_phase(120);
    set_config(4, 3, 1, 1, 1);
    run_conv_phase(100);
    set_config(7, 3, 63, 63, 1);
    run_conv_phase(120);
    set_config(0, 0, 0, 5, 0);
    run_conv_phase(80);
    set_config(2, 1, 8, 8, 1);
    run_conv_phase(120);
    set_config(3, 2, 16, 5, 0);
    run_conv_phase(120);
    repeat (3) begin
      set_config($urandom, $urandom, $urandom, $urandom, $urandom);
      run_conv_phase(80);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_queue_full();
    test_backpressure();
    test_random_layers();
    test_saturation();
    drain();
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
design/scpe_pkg.sv
design/scpe_map.sv
design/sparse_cartesian_conv_pe_top.sv
tb/sparse_cartesian_conv_pe_top_test.sv
